[rtl/srml_pkg.sv]
// ----------------------------------------------------------------------------
// srml_pkg
// Shared types and constants of the send rate meter and limiter.
// ----------------------------------------------------------------------------
package srml_pkg;

	localparam int WINDOW_SLOTS_DEF    = 16;
	localparam int SAMPLE_INTERVAL_DEF = 2000;

	localparam int LIMIT_W   = 21;
	localparam int SPEED_W   = 31;
	localparam int TIME_W    = 32;
	localparam int LEN_W     = 16;
	localparam int HELD_W    = 4;
	localparam int OP_W      = 2;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;
	localparam int KIB_SHIFT = 10;
	localparam int MUL_W     = 10;

	// divider: dividend covers bytes*1000 and the ring sum, divisor covers elapsed time and the sample count
	localparam int DVD_W = TIME_W + MUL_W;
	localparam int DVS_W = TIME_W;

	localparam logic [MUL_W-1:0]   MS_PER_S  = 10'd1000;
	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_SEND = 2'd1;

	localparam logic [PADDR_W-3:0] REG_LIMIT = '0;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [TIME_W-1:0] now_ms;
		logic [LEN_W-1:0]  sent_bytes;
	} item_t;

	typedef struct packed {
		logic               send_allowed;
		logic [SPEED_W-1:0] average_speed;
		logic [HELD_W-1:0]  samples_held;
		logic               sample_taken;
	} result_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic mul_ld;
		logic div_go;
		logic div_mean;
		logic push;
		logic mean_ld;
		logic chk_ld;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic sample_due;
		logic div_done;
	} stat_t;

endpackage

[rtl/srml_div.sv]
// ----------------------------------------------------------------------------
// srml_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srml_div
	import srml_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/srml_datapath.sv]
// ----------------------------------------------------------------------------
// srml_datapath
// Byte counter, base time, sample ring, mean, limit check and result register.
// ----------------------------------------------------------------------------
module srml_datapath
	import srml_pkg::*;
#(
	parameter int WINDOW_SLOTS       = WINDOW_SLOTS_DEF,
	parameter int SAMPLE_INTERVAL_MS = SAMPLE_INTERVAL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	input  item_t              item,
	output result_t            result,
	input  cmd_t               cmd,
	output stat_t              st
);

	localparam int IDX_W  = $clog2(WINDOW_SLOTS);
	localparam int CNTX_W = IDX_W + 1;
	localparam int SUM_W  = SPEED_W + IDX_W;
	localparam int SUMX_W = SUM_W + 1;
	localparam int LC_W   = LIMIT_W + IDX_W;

	item_t              item_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [TIME_W-1:0]  base_q;
	logic [TIME_W-1:0]  bytes_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   tail_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SPEED_W-1:0] mean_q;
	logic [DVD_W-1:0]   prod_q;
	logic [LC_W-1:0]    limcnt_q;
	logic [SPEED_W-1:0] rd_q;
	logic               taken_q;
	result_t            res_q;

	logic [SPEED_W-1:0] ring_mem [WINDOW_SLOTS];

	logic               cfg_wr;
	logic [TIME_W-1:0]  elapsed;
	logic [TIME_W:0]    bytes_add;
	logic [TIME_W-1:0]  bytes_sat;
	logic [CNTX_W-1:0]  cnt_diff;
	logic [CNTX_W-1:0]  cnt_x;
	logic [IDX_W-1:0]   cnt;
	logic [IDX_W+3:0]   cnt_ext;
	logic [IDX_W-1:0]   tail_nxt;
	logic [IDX_W-1:0]   head_nxt;
	logic               full;
	logic [DVD_W-1:0]   div_quo;
	logic               div_done;
	logic [SPEED_W-1:0] sample;
	logic [SUMX_W-1:0]  sum_add;
	logic [SUMX_W-1:0]  sum_sub;
	logic [SUM_W-1:0]   sum_nxt;
	logic               allowed;

	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_LIMIT);
	assign prdata = (paddr[PADDR_W-1:2] == REG_LIMIT) ? PDATA_W'(limit_q) : '0;

	assign elapsed   = item_q.now_ms - base_q;
	assign bytes_add = {1'b0, bytes_q} + (TIME_W + 1)'(item_q.sent_bytes);
	assign bytes_sat = bytes_add[TIME_W] ? '1 : bytes_add[TIME_W-1:0];

	// samples held, modulo the ring length
	assign cnt_diff = CNTX_W'(tail_q) - CNTX_W'(head_q);
	assign cnt_x    = (tail_q >= head_q) ? cnt_diff : cnt_diff + CNTX_W'(WINDOW_SLOTS);
	assign cnt      = cnt_x[IDX_W-1:0];
	assign cnt_ext  = {4'b0000, cnt};

	assign tail_nxt = (tail_q == IDX_W'(WINDOW_SLOTS - 1)) ? '0 : tail_q + IDX_W'(1);
	assign head_nxt = (head_q == IDX_W'(WINDOW_SLOTS - 1)) ? '0 : head_q + IDX_W'(1);
	assign full     = (tail_nxt == head_q);

	assign sample = (|div_quo[DVD_W-1:SPEED_W]) ? SPEED_MAX : div_quo[SPEED_W-1:0];

	// when the ring overflows, drop the oldest sample from the sum
	assign sum_add = {1'b0, sum_q} + SUMX_W'(sample);
	assign sum_sub = sum_add - SUMX_W'(rd_q);
	assign sum_nxt = full ? sum_sub[SUM_W-1:0] : sum_add[SUM_W-1:0];

	assign allowed = !((limit_q != '0) && (sum_q > {limcnt_q, {KIB_SHIFT{1'b0}}}));

	assign st.sample_due = (item_q.opcode == OP_TICK) && (limit_q != '0) &&
	                       (base_q != '0) && (elapsed > TIME_W'(SAMPLE_INTERVAL_MS));
	assign st.div_done   = div_done;

	srml_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (cmd.div_mean ? DVD_W'(sum_q) : prod_q),
		.divisor  (cmd.div_mean ? DVS_W'(cnt) : elapsed),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			base_q  <= '0;
			bytes_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			sum_q   <= '0;
			mean_q  <= '0;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
			base_q  <= '0;
			bytes_q <= '0;
			if (pwdata[LIMIT_W-1:0] == '0) begin
				head_q <= '0;
				tail_q <= '0;
				sum_q  <= '0;
				mean_q <= '0;
			end
		end else begin
			if (cmd.apply) begin
				if (item_q.opcode == OP_TICK && limit_q != '0 && base_q == '0) begin
					base_q <= item_q.now_ms;
				end
				if (item_q.opcode == OP_SEND) begin
					bytes_q <= bytes_sat;
				end
			end
			if (cmd.push) begin
				bytes_q <= '0;
				base_q  <= item_q.now_ms;
				tail_q  <= tail_nxt;
				sum_q   <= sum_nxt;
				if (full) begin
					head_q <= head_nxt;
				end
			end
			if (cmd.mean_ld) begin
				mean_q <= div_quo[SPEED_W-1:0];
			end
		end
	end

	// oldest sample is read ahead so it is ready when a push overflows the ring
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_mem[tail_q] <= sample;
		end
		rd_q <= ring_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= item;
			taken_q <= 1'b0;
		end
		if (cmd.push) begin
			taken_q <= 1'b1;
		end
		if (cmd.mul_ld) begin
			prod_q <= DVD_W'(bytes_q) * DVD_W'(MS_PER_S);
		end
		if (cmd.chk_ld) begin
			limcnt_q <= LC_W'(limit_q) * LC_W'(cnt);
		end
		if (cmd.out_ld) begin
			res_q.send_allowed  <= allowed;
			res_q.average_speed <= mean_q;
			res_q.samples_held  <= cnt_ext[HELD_W-1:0];
			res_q.sample_taken  <= taken_q;
		end
	end

	assign result = res_q;

endmodule

[rtl/srml_ctrl.sv]
// ----------------------------------------------------------------------------
// srml_ctrl
// Sequencer: decodes a word, runs the divider twice for a sample, hands off result.
// ----------------------------------------------------------------------------
module srml_ctrl
	import srml_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	output logic  result_valid,
	input  logic  result_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_DIVS_GO = 4'd2;
	localparam logic [3:0] S_DIVS    = 4'd3;
	localparam logic [3:0] S_PUSH    = 4'd4;
	localparam logic [3:0] S_DIVM_GO = 4'd5;
	localparam logic [3:0] S_DIVM    = 4'd6;
	localparam logic [3:0] S_CHECK   = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.sample_due) begin
					cmd.mul_ld = 1'b1;
					state_d    = S_DIVS_GO;
				end else begin
					cmd.apply = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_DIVS_GO: begin
				cmd.div_go = 1'b1;
				state_d    = S_DIVS;
			end
			S_DIVS: begin
				if (st.div_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_DIVM_GO;
			end
			S_DIVM_GO: begin
				cmd.div_go   = 1'b1;
				cmd.div_mean = 1'b1;
				state_d      = S_DIVM;
			end
			S_DIVM: begin
				if (st.div_done) begin
					cmd.mean_ld = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.chk_ld = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				// hold until the result register is free
				if (!out_valid_q || result_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

endmodule

[rtl/send_rate_meter_limiter.sv]
// ----------------------------------------------------------------------------
// send_rate_meter_limiter
// Transmit bandwidth meter with a ring of speed samples and a send gate.
// ----------------------------------------------------------------------------
//  port group       direction  content
//  item_*           in         opcode, now_ms, sent_bytes
//  result_*         out        send_allowed, average_speed, samples_held, sample_taken
//  p* (APB)         in/out     limit_kib at byte address 0
//
//  A send, request, idle tick or starting tick passes through decode, check
//  and finish before its result is loaded. A tick that closes an interval
//  instead runs the shared one-bit-per-cycle divider to form the sample,
//  pushes it into the ring, runs the divider again for the ring mean, then
//  checks and finishes. A new word is taken only back in idle.
//  A new word is accepted while the previous result still waits in the
//  result register; the sequencer holds only when a second result is ready.
//  Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module send_rate_meter_limiter
	import srml_pkg::*;
#(
	parameter int WINDOW_SLOTS       = WINDOW_SLOTS_DEF,
	parameter int SAMPLE_INTERVAL_MS = SAMPLE_INTERVAL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result
);

	cmd_t  cmd;
	stat_t st;

	assign pready = 1'b1;

	srml_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.st           (st),
		.cmd          (cmd)
	);

	srml_datapath #(
		.WINDOW_SLOTS       (WINDOW_SLOTS),
		.SAMPLE_INTERVAL_MS (SAMPLE_INTERVAL_MS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.item    (item),
		.result  (result),
		.cmd     (cmd),
		.st      (st)
	);

	// a push follows directly on the sample division finishing
	a_push_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> $past(st.div_done))
		else $error("ring push without a finished division");

	// no new word while a division is in flight
	a_busy_blocks_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |=> !item_ready)
		else $error("word accepted during division");

	a_load_vs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.out_ld))
		else $error("word load and result load in the same cycle");

	// a result register load while full must coincide with the old word leaving
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ld && result_valid) |-> result_ready)
		else $error("result overwritten before delivery");

endmodule
